// ===== rtl/core/asgi_pkg.sv =====
// ----------------------------------------------------------------------------
// asgi_pkg
// Shared types, constants and helpers for the greedy acute-set insertion block.
// ----------------------------------------------------------------------------
`default_nettype none

package asgi_pkg;

   // Store geometry
   localparam int SET_CAPACITY = 512;
   localparam int POINT_BITS   = 32;
   localparam int ADDR_W       = $clog2(SET_CAPACITY);
   localparam int CNT_W        = $clog2(SET_CAPACITY + 1);

   // Field widths of the interface
   localparam int PT_W      = 32;
   localparam int DIM_W     = 6;
   localparam int TARGET_W  = 10;
   localparam int COUNT_W   = 10;
   localparam int REASON_W  = 3;
   localparam int WIDE_W    = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;
   localparam int WIDE_OUT  = (WIDE_W > COUNT_W) ? WIDE_W : COUNT_W;

   // Register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SIZE = 1'd1;

   localparam logic [DIM_W-1:0]    DIM_RESET    = 6'd32;
   localparam logic [TARGET_W-1:0] TARGET_RESET = 10'd512;

   // Result codes
   typedef enum logic [REASON_W-1:0] {
      REASON_NONE      = 3'd0,
      REASON_DUPLICATE = 3'd1,
      REASON_AT_CAND   = 3'd2,
      REASON_AT_APEX   = 3'd3,
      REASON_TARGET    = 3'd4
   } reason_type;

   // Scan phase selects the test applied to each streamed word
   typedef enum logic [1:0] {
      PH_DUP  = 2'd0,
      PH_PAIR = 2'd1,
      PH_APEX = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DUP,
      ST_PAIR_LOAD,
      ST_PAIR_SCAN,
      ST_APEX_LOAD,
      ST_APEX_SCAN,
      ST_RESULT
   } state_type;

   // Payloads
   typedef struct packed {
      logic [PT_W-1:0] point;
      logic            restart;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [REASON_W-1:0] reject_reason;
      logic [COUNT_W-1:0]  set_count;
      logic                target_reached;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       accept;
      logic       scan_init;
      logic       scan_run;
      logic       outer_init;
      logic       outer_next;
      logic       load_base;
      logic       commit;
      phase_type  phase;
      reason_type reason;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic full;
      logic hit;
      logic scan_end;
      logic i_valid;
      logic slot_free;
   } sts_type;

   // Coordinate mask: bit k kept when k is below the dimension
   function automatic logic [POINT_BITS-1:0] coord_mask(input logic [DIM_W-1:0] dim);
      logic [POINT_BITS-1:0] m;
      for (int k = 0; k < POINT_BITS; k++) begin
         m[k] = (DIM_W'(k) < dim);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/asgi_ram.sv =====
// ----------------------------------------------------------------------------
// asgi_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module asgi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/asgi_ctrl.sv =====
// ----------------------------------------------------------------------------
// asgi_ctrl
// Sequencer: duplicate scan, candidate-apex pair scan, stored-apex scan, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module asgi_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire asgi_pkg::sts_type sts,
   output asgi_pkg::cmd_type      cmd
);

   asgi_pkg::state_type  state_ff, state_in;
   asgi_pkg::reason_type reason_ff, reason_in;

   // State and verdict registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= asgi_pkg::ST_IDLE;
         reason_ff <= asgi_pkg::REASON_NONE;
      end else begin
         state_ff  <= state_in;
         reason_ff <= reason_in;
      end
   end

   // Next state and verdict
   always_comb begin
      state_in  = state_ff;
      reason_in = reason_ff;
      unique case (state_ff)
         asgi_pkg::ST_IDLE: begin
            if (req_valid) state_in = asgi_pkg::ST_START;
         end
         asgi_pkg::ST_START: begin
            if (sts.full) begin
               state_in  = asgi_pkg::ST_RESULT;
               reason_in = asgi_pkg::REASON_TARGET;
            end else begin
               state_in = asgi_pkg::ST_DUP;
            end
         end
         asgi_pkg::ST_DUP: begin
            if (sts.hit) begin
               state_in  = asgi_pkg::ST_RESULT;
               reason_in = asgi_pkg::REASON_DUPLICATE;
            end else if (sts.scan_end) begin
               state_in = asgi_pkg::ST_PAIR_LOAD;
            end
         end
         asgi_pkg::ST_PAIR_LOAD: begin
            state_in = sts.i_valid ? asgi_pkg::ST_PAIR_SCAN : asgi_pkg::ST_APEX_LOAD;
         end
         asgi_pkg::ST_PAIR_SCAN: begin
            if (sts.hit) begin
               state_in  = asgi_pkg::ST_RESULT;
               reason_in = asgi_pkg::REASON_AT_CAND;
            end else if (sts.scan_end) begin
               state_in = asgi_pkg::ST_PAIR_LOAD;
            end
         end
         asgi_pkg::ST_APEX_LOAD: begin
            if (sts.i_valid) begin
               state_in = asgi_pkg::ST_APEX_SCAN;
            end else begin
               state_in  = asgi_pkg::ST_RESULT;
               reason_in = asgi_pkg::REASON_NONE;
            end
         end
         asgi_pkg::ST_APEX_SCAN: begin
            if (sts.hit) begin
               state_in  = asgi_pkg::ST_RESULT;
               reason_in = asgi_pkg::REASON_AT_APEX;
            end else if (sts.scan_end) begin
               state_in = asgi_pkg::ST_APEX_LOAD;
            end
         end
         asgi_pkg::ST_RESULT: begin
            if (sts.slot_free) state_in = asgi_pkg::ST_IDLE;
         end
         default: state_in = asgi_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.phase  = asgi_pkg::PH_DUP;
      cmd.reason = reason_ff;
      unique case (state_ff)
         asgi_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         asgi_pkg::ST_START: begin
            cmd.scan_init = !sts.full;
         end
         asgi_pkg::ST_DUP: begin
            cmd.scan_run   = 1'b1;
            cmd.outer_init = sts.scan_end;
         end
         asgi_pkg::ST_PAIR_LOAD: begin
            cmd.phase      = asgi_pkg::PH_PAIR;
            cmd.load_base  = sts.i_valid;
            cmd.scan_init  = sts.i_valid;
            cmd.outer_init = !sts.i_valid;
         end
         asgi_pkg::ST_PAIR_SCAN: begin
            cmd.phase      = asgi_pkg::PH_PAIR;
            cmd.scan_run   = 1'b1;
            cmd.outer_next = sts.scan_end;
         end
         asgi_pkg::ST_APEX_LOAD: begin
            cmd.phase     = asgi_pkg::PH_APEX;
            cmd.load_base = sts.i_valid;
            cmd.scan_init = sts.i_valid;
         end
         asgi_pkg::ST_APEX_SCAN: begin
            cmd.phase      = asgi_pkg::PH_APEX;
            cmd.scan_run   = 1'b1;
            cmd.outer_next = sts.scan_end;
         end
         asgi_pkg::ST_RESULT: begin
            cmd.commit = sts.slot_free;
         end
         default: ;
      endcase
   end

`ifndef SYNTH
   // A waiting result must hold the sequencer in place
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == asgi_pkg::ST_RESULT && !sts.slot_free) |=> state_ff == asgi_pkg::ST_RESULT)
      else $error("asgi_ctrl: left result state while output slot busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/asgi_dpath.sv =====
// ----------------------------------------------------------------------------
// asgi_dpath
// Vertex store, scan counters, right-angle tests, config and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module asgi_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire asgi_pkg::req_type                   req_data,
   input  wire logic                                csr_we,
   input  wire logic [asgi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [asgi_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire asgi_pkg::cmd_type                   cmd,
   output asgi_pkg::sts_type                        sts,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output asgi_pkg::rsp_type                        rsp_data
);

   localparam int AW = asgi_pkg::ADDR_W;
   localparam int CW = asgi_pkg::CNT_W;
   localparam int PW = asgi_pkg::POINT_BITS;
   localparam int WW = asgi_pkg::WIDE_OUT;

   logic [asgi_pkg::DIM_W-1:0]    dim_ff, dim_in;
   logic [asgi_pkg::TARGET_W-1:0] target_ff, target_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [PW-1:0]                 x_ff, x_in;
   logic [CW-1:0]                 i_ff, i_in;
   logic [CW-1:0]                 j_ff, j_in;
   logic [PW-1:0]                 base_ff, base_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic                          rd_base_ff, rd_base_in;
   logic [CW-1:0]                 rd_idx_ff, rd_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   asgi_pkg::rsp_type             rsp_ff, rsp_in;

   logic [PW-1:0] rd_data;
   logic [AW-1:0] rd_addr;
   logic          issue;
   logic          wr_en;
   logic [WW-1:0] tgt_eff;
   logic [WW-1:0] count_wide;
   logic [WW-1:0] count_next_wide;
   logic [CW-1:0] count_next;
   logic [CW:0]   i_plus;
   logic          is_accept;
   logic          test_hit;
   logic          outer_valid;

   // Configuration registers
   always_comb begin
      dim_in    = dim_ff;
      target_in = target_ff;
      if (csr_we) begin
         unique case (csr_index)
            asgi_pkg::CSR_DIMENSION:   dim_in    = csr_wdata[asgi_pkg::DIM_W-1:0];
            asgi_pkg::CSR_TARGET_SIZE: target_in = csr_wdata[asgi_pkg::TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective target limited to capacity
   assign tgt_eff = (WW'(target_ff) > WW'(asgi_pkg::SET_CAPACITY))
                    ? WW'(asgi_pkg::SET_CAPACITY) : WW'(target_ff);
   assign count_wide = WW'(count_ff);

   // Read issue: base word at i, or streamed word at j while below count
   assign issue   = cmd.scan_run && (j_ff < count_ff);
   assign rd_addr = cmd.load_base ? i_ff[AW-1:0] : j_ff[AW-1:0];

   assign rd_vld_in  = issue;
   assign rd_base_in = cmd.load_base;
   assign rd_idx_in  = j_ff;
   assign base_in    = rd_base_ff ? rd_data : base_ff;

   // Scan counters
   assign i_plus = {1'b0, i_ff} + 1'b1;
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      if (cmd.outer_init) begin
         i_in = '0;
      end else if (cmd.outer_next) begin
         i_in = i_plus[CW-1:0];
      end
      if (cmd.scan_init) begin
         unique case (cmd.phase)
            asgi_pkg::PH_PAIR: j_in = i_plus[CW-1:0];
            default:           j_in = '0;
         endcase
      end else if (issue) begin
         j_in = j_ff + 1'b1;
      end
   end

   // Candidate capture
   assign x_in = req_data.point[PW-1:0] & asgi_pkg::coord_mask(dim_ff);

   // Test of one streamed word against candidate and base
   always_comb begin
      test_hit = 1'b0;
      if (rd_vld_ff) begin
         unique case (cmd.phase)
            asgi_pkg::PH_DUP:  test_hit = (rd_data == x_ff);
            asgi_pkg::PH_PAIR: test_hit = (((base_ff ^ x_ff) & (rd_data ^ x_ff)) == '0);
            asgi_pkg::PH_APEX: test_hit = (rd_idx_ff != i_ff)
                                       && (((x_ff ^ base_ff) & (rd_data ^ base_ff)) == '0);
            default:           test_hit = 1'b0;
         endcase
      end
   end

   // Outer index still inside its range
   always_comb begin
      unique case (cmd.phase)
         asgi_pkg::PH_PAIR: outer_valid = (i_plus < {1'b0, count_ff});
         asgi_pkg::PH_APEX: outer_valid = (i_ff < count_ff);
         default:           outer_valid = 1'b0;
      endcase
   end

   // Status to the sequencer
   always_comb begin
      sts           = '0;
      sts.hit       = test_hit;
      sts.i_valid   = outer_valid;
      sts.full      = (count_wide >= tgt_eff);
      sts.scan_end  = (j_ff >= count_ff) && !rd_vld_ff;
      sts.slot_free = !rsp_valid_ff || rsp_ready;
   end

   // Commit: append on acceptance and build the result
   assign is_accept       = (cmd.reason == asgi_pkg::REASON_NONE);
   assign wr_en           = cmd.commit && is_accept;
   assign count_next      = wr_en ? count_ff + 1'b1 : count_ff;
   assign count_next_wide = WW'(count_next);

   always_comb begin
      count_in = count_next;
      if (cmd.accept && req_data.restart) begin
         count_in = '0;
      end
   end

   always_comb begin
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.commit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.accepted       = is_accept;
         rsp_in.reject_reason  = cmd.reason;
         rsp_in.set_count      = count_next_wide[asgi_pkg::COUNT_W-1:0];
         rsp_in.target_reached = (count_next_wide >= tgt_eff);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= asgi_pkg::DIM_RESET;
         target_ff    <= asgi_pkg::TARGET_RESET;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rd_base_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dim_ff       <= dim_in;
         target_ff    <= target_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rd_base_ff   <= rd_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) x_ff <= x_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      base_ff   <= base_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
   end

   // Vertex store
   asgi_ram #(
      .WIDTH (PW),
      .DEPTH (asgi_pkg::SET_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (x_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // Fill never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(asgi_pkg::SET_CAPACITY))
      else $error("asgi_dpath: vertex count beyond capacity");

   // An append only happens below the target
   a_append_below: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_wide < tgt_eff))
      else $error("asgi_dpath: vertex appended at or above target");

   // A result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("asgi_dpath: result register overwritten");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/acute_set_greedy_insert.sv =====
// ----------------------------------------------------------------------------
// acute_set_greedy_insert
// Top level: greedy insertion of hypercube vertices into an acute set.
// ----------------------------------------------------------------------------
// One candidate is processed at a time. With m vertices stored (m at least
// one), an accepted candidate passes a duplicate scan that streams all m
// words, then a pair scan that streams the words above each of the first
// m - 1 base words, then a stored-apex scan that streams all m words for
// each of the m apexes. Every streamed word costs one read on the single read
// port of the vertex RAM, and each base word adds a load state and a drain of
// the registered read. An early reject stops the scan at the first failing
// test. With a full set the candidate goes from the start state straight to
// the result state with no scan. The result sits in an output register, so the
// next candidate may be taken while it waits; a second result stalls the
// block until the first has gone. Stored words are only read below the fill
// count, so the RAM needs no clearing after reset; a restart simply zeroes
// the count.
`default_nettype none

module acute_set_greedy_insert (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire asgi_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output asgi_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [asgi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [asgi_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   asgi_pkg::cmd_type cmd;
   asgi_pkg::sts_type sts;

   // Sequencer
   asgi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store, tests and result register
   asgi_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the greedy acute-set insertion block.
// ----------------------------------------------------------------------------
// Every candidate transfer is fed to a scoreboard. The scoreboard keeps its own
// copy of the vertex set and the two registers and works out the verdict that
// the candidate must get. Each result transfer is checked field by field
// against the oldest outstanding verdict. A directed opening covers empty and
// full sets, duplicates, both kinds of right angle, the target limit and the
// dimension extremes. Random phases follow with fresh register settings,
// candidates built from earlier ones, random gaps on both channels, one long
// result stall and one full drain in mid-phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   import asgi_pkg::*;

   localparam int     CLOCK_PERIOD  = 12;
   localparam int     RESET_CYCLES  = 6;
   localparam int     RANDOM_ITEMS  = 75;
   localparam int     SETTLE_CYCLES = 12;
   localparam int     LONG_HOLD     = 600;
   localparam int     RECENT_DEPTH  = 32;
   localparam longint TIMEOUT_CYCLES = 64'd2_000_000;

   // Predicts the verdict for each candidate and checks the block's answers
   class acute_insert_scoreboard;
      logic [POINT_BITS-1:0] vertices[SET_CAPACITY];
      int                    fill;
      int                    largest_fill;
      logic [DIM_W-1:0]      dimension;
      logic [TARGET_W-1:0]   target_size;
      rsp_type               awaited[$];
      int                    mismatches;
      int                    reason_seen[5];
      int                    register_writes;

      function new();
         fill            = 0;
         largest_fill    = 0;
         dimension       = DIM_RESET;
         target_size     = TARGET_RESET;
         mismatches      = 0;
         register_writes = 0;
         foreach (reason_seen[k]) reason_seen[k] = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report_mismatch(input string what, input int got, input int want);
         mismatches++;
         $display("MISMATCH at %0t: %s got %0d, wanted %0d", $time, what, got, want);
      endtask

      function void note_register(input logic [CSR_IDX_W-1:0] index,
                                  input logic [CSR_DATA_W-1:0] value);
         register_writes++;
         if (index == CSR_DIMENSION) dimension = value[DIM_W-1:0];
         else if (index == CSR_TARGET_SIZE) target_size = value[TARGET_W-1:0];
      endfunction

      function logic [POINT_BITS-1:0] coordinate_mask();
         int d;
         d = (int'(dimension) > POINT_BITS) ? POINT_BITS : int'(dimension);
         if (d == 0) return '0;
         return {POINT_BITS{1'b1}} >> (POINT_BITS - d);
      endfunction

      // Duplicate scan, then candidate as apex, then stored apex
      function reason_type right_angle_scan(input logic [POINT_BITS-1:0] x);
         logic [POINT_BITS-1:0] leg;
         for (int i = 0; i < fill; i++)
            if (vertices[i] == x) return REASON_DUPLICATE;
         for (int i = 0; i < fill; i++) begin
            leg = vertices[i] ^ x;
            for (int j = i + 1; j < fill; j++)
               if ((leg & (vertices[j] ^ x)) == '0) return REASON_AT_CAND;
         end
         for (int i = 0; i < fill; i++) begin
            leg = x ^ vertices[i];
            for (int j = 0; j < fill; j++)
               if (j != i && (leg & (vertices[j] ^ vertices[i])) == '0)
                  return REASON_AT_APEX;
         end
         return REASON_NONE;
      endfunction

      function void note_request(input req_type item);
         logic [POINT_BITS-1:0] x;
         int                    goal;
         reason_type            why;
         rsp_type               verdict;
         x = item.point & coordinate_mask();
         if (item.restart) fill = 0;
         goal = (int'(target_size) > SET_CAPACITY) ? SET_CAPACITY : int'(target_size);
         if (fill >= goal) why = REASON_TARGET;
         else why = right_angle_scan(x);
         if (why == REASON_NONE) begin
            vertices[fill] = x;
            fill++;
         end
         if (fill > largest_fill) largest_fill = fill;
         verdict.accepted       = (why == REASON_NONE);
         verdict.reject_reason  = why;
         verdict.set_count      = COUNT_W'(fill);
         verdict.target_reached = (fill >= goal);
         awaited.push_back(verdict);
      endfunction

      task check_result(input rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report_mismatch("result with nothing outstanding, set_count", got.set_count, -1);
            return;
         end
         want = awaited.pop_front();
         if (want.reject_reason < 5) reason_seen[want.reject_reason]++;
         if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
         if (got.reject_reason !== want.reject_reason)
            report_mismatch("reject_reason", got.reject_reason, want.reject_reason);
         if (got.set_count !== want.set_count)
            report_mismatch("set_count", got.set_count, want.set_count);
         if (got.target_reached !== want.target_reached)
            report_mismatch("target_reached", got.target_reached, want.target_reached);
      endtask
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DIMENSION;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   acute_insert_scoreboard insert_board = new();
   logic [POINT_BITS-1:0]  recent_points[$];
   int                     hold_request = 0;
   bit                     calm = 1'b0;
   int                     candidates_sent = 0;

   acute_set_greedy_insert dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) insert_board.check_result(rsp_data);
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   // Result side: random stalls, one long hold-off on request
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_request = 0;
            stall_left   = LONG_HOLD;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_item(input logic [POINT_BITS-1:0] point, input logic restart);
      req_type item;
      item.point   = point;
      item.restart = restart;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      insert_board.note_request(item);
      candidates_sent++;
      recent_points.push_back(point);
      if (recent_points.size() > RECENT_DEPTH) void'(recent_points.pop_front());
   endtask

   task automatic wait_all_results();
      idle_sender(1);
      while (insert_board.pending() != 0) @(posedge clock);
   endtask

   // Registers are only written with the block idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      insert_board.note_register(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Candidates: random, sparse, or near an earlier one to provoke right angles
   function automatic logic [POINT_BITS-1:0] make_candidate();
      logic [POINT_BITS-1:0] base;
      int                    kind;
      kind = $urandom_range(0, 9);
      if (recent_points.size() == 0 || kind < 3) return $urandom;
      base = recent_points[$urandom_range(0, recent_points.size() - 1)];
      case (kind)
         3, 4: return $urandom & $urandom & $urandom;
         5, 6: return base ^ (32'd1 << $urandom_range(0, POINT_BITS - 1));
         7:    return base;
         8:    return base ^ recent_points[$urandom_range(0, recent_points.size() - 1)];
         default: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return '1;
               default: return base & $urandom;
            endcase
         end
      endcase
   endfunction

   task automatic directed_opening();
      // empty set, duplicate, apex at the candidate
      send_item(32'h0000_0000, 1'b1);
      send_item(32'h0000_0000, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h0000_FFFF, 1'b0);
      // apex at a stored vertex, then at the candidate
      send_item(32'h0000_0000, 1'b1);
      send_item(32'h0000_0003, 1'b0);
      send_item(32'h0000_0004, 1'b0);
      send_item(32'h0000_0001, 1'b0);
      // small target: fill up, then refuse
      write_register(CSR_TARGET_SIZE, 10'd2);
      send_item(32'h0000_0005, 1'b1);
      send_item(32'h0000_000A, 1'b0);
      send_item(32'h0000_00F0, 1'b0);
      // zero target refuses even a fresh set
      write_register(CSR_TARGET_SIZE, 10'd0);
      send_item(32'h0000_0007, 1'b1);
      // target beyond capacity is clipped
      write_register(CSR_TARGET_SIZE, 10'd1023);
      send_item(32'hAAAA_AAAA, 1'b1);
      send_item(32'h5555_5555, 1'b0);
      // empty mask folds everything onto vertex zero
      write_register(CSR_DIMENSION, 10'd0);
      send_item(32'hFFFF_FFFF, 1'b1);
      send_item(32'h1234_5678, 1'b0);
      write_register(CSR_DIMENSION, 10'd1);
      send_item(32'hFFFF_FFFE, 1'b1);
      send_item(32'h0000_0001, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      // oversized dimension saturates; stored words keep their old mask
      write_register(CSR_DIMENSION, 10'd63);
      send_item(32'hFFFF_FFFF, 1'b0);
      write_register(CSR_DIMENSION, 10'd32);
      write_register(CSR_TARGET_SIZE, 10'd512);
   endtask

   task automatic random_phases();
      int                    phase;
      int                    count;
      int                    sent;
      int                    dim_pick;
      int                    target_pick;
      bit                    fresh;
      logic [POINT_BITS-1:0] point;
      logic                  restart;
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       dim_pick = 0;
            1:       dim_pick = 1;
            2:       dim_pick = 63;
            3:       dim_pick = 32;
            4, 5:    dim_pick = $urandom_range(2, 32);
            default: dim_pick = $urandom_range(2, 8);
         endcase
         case ($urandom_range(0, 11))
            0:       target_pick = 0;
            1:       target_pick = 1;
            2:       target_pick = 1023;
            3:       target_pick = 512;
            default: target_pick = $urandom_range(2, 40);
         endcase
         if (phase == 0 || $urandom_range(0, 1) == 0)
            write_register(CSR_DIMENSION, CSR_DATA_W'(dim_pick));
         if (phase == 0 || $urandom_range(0, 1) == 0)
            write_register(CSR_TARGET_SIZE, CSR_DATA_W'(target_pick));
         // big targets: short phase on a fresh set keeps the scan cheap
         if (insert_board.target_size >= SET_CAPACITY) begin
            count = $urandom_range(4, 8);
            fresh = 1'b1;
         end else begin
            count = $urandom_range(6, 14);
            fresh = ($urandom_range(0, 1) == 0);
         end
         calm = (phase % 3 == 2);
         if (phase == 2) hold_request = 1;
         for (int k = 0; k < count; k++) begin
            if (!calm) idle_sender(pick_gap());
            point   = make_candidate();
            restart = (k == 0 && fresh) || ($urandom_range(0, 11) == 0);
            send_item(point, restart);
            sent++;
            if (phase == 1 && k == count / 2) wait_all_results();
         end
         phase++;
      end
      calm = 1'b0;
   endtask

   // Stimulus and end of run
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_opening();
      random_phases();
      wait_all_results();
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      $display("run: %0d candidates, %0d inserted, %0d duplicate, %0d right angle at candidate,",
               candidates_sent, insert_board.reason_seen[REASON_NONE],
               insert_board.reason_seen[REASON_DUPLICATE],
               insert_board.reason_seen[REASON_AT_CAND]);
      $display("run: %0d at stored apex, %0d over target, largest set %0d, %0d register writes",
               insert_board.reason_seen[REASON_AT_APEX],
               insert_board.reason_seen[REASON_TARGET],
               insert_board.largest_fill, insert_board.register_writes);
      if (insert_board.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout with %0d results outstanding", insert_board.pending());
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/asgi_pkg.sv
rtl/core/asgi_ram.sv
rtl/core/asgi_ctrl.sv
rtl/core/asgi_dpath.sv
rtl/core/acute_set_greedy_insert.sv
tb/sv/tb_top.sv
